// ===== sv/sarp_pkg.sv =====
// ----------------------------------------------------------------------------
// sarp_pkg
// shared widths, register indexes and word types for the rolloff/pan block
// ----------------------------------------------------------------------------
package sarp_pkg;

  localparam int COORD_BITS   = 24;
  localparam int FRAC_BITS    = 14;
  localparam int VEC_BITS     = FRAC_BITS + 2;
  localparam int GAIN_BITS    = FRAC_BITS + 1;
  localparam int ROLL_BITS    = COORD_BITS - 1;
  localparam int NUM_REGS     = 6;
  localparam int REG_IDX_BITS = 3;

  localparam logic [GAIN_BITS-1:0] ONE_Q = GAIN_BITS'(1) << FRAC_BITS;

  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_LISTENER_X = 3'd0,
    REG_LISTENER_Y = 3'd1,
    REG_LISTENER_Z = 3'd2,
    REG_RIGHT_X    = 3'd3,
    REG_RIGHT_Y    = 3'd4,
    REG_RIGHT_Z    = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] source_x;
    logic signed [COORD_BITS-1:0] source_y;
    logic signed [COORD_BITS-1:0] source_z;
    logic        [ROLL_BITS-1:0]  rolloff_distance;
  } in_t;

  typedef struct packed {
    logic        [GAIN_BITS-1:0] gain;
    logic signed [VEC_BITS-1:0]  pan;
  } out_t;

  // gain and pan selection flags that ride along the gain divider
  typedef struct packed {
    logic zero_dist;
    logic unity;
    logic silent;
    logic pan_sat;
  } gain_flags_t;

endpackage

// ===== sv/sarp_sqrt.sv =====
// ----------------------------------------------------------------------------
// sarp_sqrt
// pipelined integer square root, one result bit per register stage
// ----------------------------------------------------------------------------
module sarp_sqrt #(
  parameter int SW  = 52,
  parameter int RW  = 25,
  parameter int SBW = 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  logic [SW-1:0]  rad_i,
  input  logic [SBW-1:0] sb_i,
  output logic           valid_o,
  output logic [RW-1:0]  root_o,
  output logic [SBW-1:0] sb_o
);

  localparam int IW = (SW > 2 * RW + 1) ? SW : 2 * RW + 1;

  logic [IW-1:0]  rem_s  [RW+1];
  logic [RW-1:0]  root_s [RW+1];
  logic           vld_s  [RW+1];
  logic [SBW-1:0] sb_s   [RW+1];

  logic [IW-1:0]  rem_q  [RW];
  logic [RW-1:0]  root_q [RW];
  logic           vld_q  [RW];
  logic [SBW-1:0] sb_q   [RW];

  assign rem_s[0]  = IW'(rad_i);
  assign root_s[0] = '0;
  assign vld_s[0]  = valid_i;
  assign sb_s[0]   = sb_i;

  for (genvar i = 0; i < RW; i++) begin : g_stage
    localparam int B = RW - 1 - i;
    logic [IW-1:0] trial;

    // (root + 2^b)^2 - root^2
    assign trial = (IW'(root_s[i]) << (B + 1)) + (IW'(1) << (2 * B));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= vld_s[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rem_s[i] >= trial) begin
        rem_q[i]  <= rem_s[i] - trial;
        root_q[i] <= root_s[i] | (RW'(1) << B);
      end else begin
        rem_q[i]  <= rem_s[i];
        root_q[i] <= root_s[i];
      end
      sb_q[i] <= sb_s[i];
    end

    assign rem_s[i+1]  = rem_q[i];
    assign root_s[i+1] = root_q[i];
    assign vld_s[i+1]  = vld_q[i];
    assign sb_s[i+1]   = sb_q[i];
  end

  assign valid_o = vld_s[RW];
  assign root_o  = root_s[RW];
  assign sb_o    = sb_s[RW];

endmodule

// ===== sv/sarp_div.sv =====
// ----------------------------------------------------------------------------
// sarp_div
// pipelined restoring divider, one quotient bit per register stage
// ----------------------------------------------------------------------------
module sarp_div #(
  parameter int XW  = 37,
  parameter int DVW = 23,
  parameter int QW  = 15,
  parameter int SBW = 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  logic [XW-1:0]  num_i,
  input  logic [DVW-1:0] den_i,
  input  logic [SBW-1:0] sb_i,
  output logic           valid_o,
  output logic [QW-1:0]  quot_o,
  output logic [SBW-1:0] sb_o
);

  // quotient must fit in QW bits, otherwise the result is meaningless
  localparam int IW = (XW > DVW + QW) ? XW : DVW + QW;

  logic [IW-1:0]  rem_s [QW+1];
  logic [DVW-1:0] den_s [QW+1];
  logic [QW-1:0]  quo_s [QW+1];
  logic           vld_s [QW+1];
  logic [SBW-1:0] sb_s  [QW+1];

  logic [IW-1:0]  rem_q [QW];
  logic [DVW-1:0] den_q [QW];
  logic [QW-1:0]  quo_q [QW];
  logic           vld_q [QW];
  logic [SBW-1:0] sb_q  [QW];

  assign rem_s[0] = IW'(num_i);
  assign den_s[0] = den_i;
  assign quo_s[0] = '0;
  assign vld_s[0] = valid_i;
  assign sb_s[0]  = sb_i;

  for (genvar i = 0; i < QW; i++) begin : g_stage
    localparam int K = QW - 1 - i;
    logic [IW-1:0] trial;

    assign trial = IW'(den_s[i]) << K;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= vld_s[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rem_s[i] >= trial) begin
        rem_q[i] <= rem_s[i] - trial;
        quo_q[i] <= quo_s[i] | (QW'(1) << K);
      end else begin
        rem_q[i] <= rem_s[i];
        quo_q[i] <= quo_s[i];
      end
      den_q[i] <= den_s[i];
      sb_q[i]  <= sb_s[i];
    end

    assign rem_s[i+1] = rem_q[i];
    assign den_s[i+1] = den_q[i];
    assign quo_s[i+1] = quo_q[i];
    assign vld_s[i+1] = vld_q[i];
    assign sb_s[i+1]  = sb_q[i];
  end

  assign valid_o = vld_s[QW];
  assign quot_o  = quo_s[QW];
  assign sb_o    = sb_s[QW];

endmodule

// ===== sv/spatial_audio_rolloff_pan_top.sv =====
// ----------------------------------------------------------------------------
// spatial_audio_rolloff_pan_top
// distance gain with linear rolloff and stereo pan for one source per cycle
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  input    | start_i, busy_o      | in_word_i  (source x/y/z, rolloff)
//  result   | done_o (strobe)      | out_word_o (gain, pan)
//  config   | cfg_we_i             | cfg_idx_i, cfg_wdata_i
//
//  a new word is taken every cycle; busy_o stays low
//  each word passes through stages a to c, the bit-per-stage square root,
//  stage d, the bit-per-stage dividers and the output register
//  reset clears the valid bits of every stage and loads the default listener
//  the receiver cannot stall, so no stage ever holds
// ----------------------------------------------------------------------------
module spatial_audio_rolloff_pan_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  sarp_pkg::in_t                        in_word_i,
  output logic                                 done_o,
  output sarp_pkg::out_t                       out_word_o,
  input  logic                                 cfg_we_i,
  input  logic [sarp_pkg::REG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [sarp_pkg::COORD_BITS-1:0]      cfg_wdata_i
);

  import sarp_pkg::*;

  // datapath widths
  localparam int DW   = COORD_BITS + 1;           // coordinate difference
  localparam int SQW  = 2 * DW;                   // one square
  localparam int SUMW = SQW + 2;                  // sum of three squares
  localparam int RW   = COORD_BITS + 1;           // distance
  localparam int PRW  = DW + VEC_BITS;            // one dot product term
  localparam int PW   = PRW + 2;                  // dot product
  localparam int GXW  = ROLL_BITS + FRAC_BITS;    // gain dividend
  localparam int QW   = GAIN_BITS;                // quotient bits
  localparam int CW   = (PW > RW + QW) ? PW : RW + QW;
  localparam int SBW  = ROLL_BITS + PW + 1;
  localparam int LAT  = 3 + RW + 1 + QW + 1;

  // configuration registers
  logic signed [COORD_BITS-1:0] lis_q [3];
  logic signed [VEC_BITS-1:0]   rgt_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lis_q[0] <= '0;
      lis_q[1] <= '0;
      lis_q[2] <= '0;
      rgt_q[0] <= VEC_BITS'(ONE_Q);
      rgt_q[1] <= '0;
      rgt_q[2] <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LISTENER_X: lis_q[0] <= cfg_wdata_i;
        REG_LISTENER_Y: lis_q[1] <= cfg_wdata_i;
        REG_LISTENER_Z: lis_q[2] <= cfg_wdata_i;
        REG_RIGHT_X:    rgt_q[0] <= cfg_wdata_i[VEC_BITS-1:0];
        REG_RIGHT_Y:    rgt_q[1] <= cfg_wdata_i[VEC_BITS-1:0];
        REG_RIGHT_Z:    rgt_q[2] <= cfg_wdata_i[VEC_BITS-1:0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // fully pipelined, never stalls
  assign busy_o = 1'b0;

  logic signed [COORD_BITS-1:0] src [3];
  assign src[0] = in_word_i.source_x;
  assign src[1] = in_word_i.source_y;
  assign src[2] = in_word_i.source_z;

  // stage a: offset from listener
  logic                  va_q;
  logic signed [DW-1:0]  diff_q [3];
  logic [ROLL_BITS-1:0]  roll_a_q;

  // stage b: squares and dot product terms
  logic                  vb_q;
  logic [SQW-1:0]        sq_q [3];
  logic signed [PRW-1:0] prod_q [3];
  logic [ROLL_BITS-1:0]  roll_b_q;
  logic [DW-1:0]         mag [3];

  // stage c: sums
  logic                  vc_q;
  logic [SUMW-1:0]       sum_q;
  logic [PW-1:0]         dmag_q;
  logic                  neg_q;
  logic [ROLL_BITS-1:0]  roll_c_q;
  logic signed [PW-1:0]  dot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      va_q <= start_i & ~busy_o;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      mag[j] = diff_q[j][DW-1] ? DW'(-diff_q[j]) : DW'(diff_q[j]);
    end
    dot = PW'(prod_q[0]) + PW'(prod_q[1]) + PW'(prod_q[2]);
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) begin
      diff_q[j] <= DW'(src[j]) - DW'(lis_q[j]);
      sq_q[j]   <= SQW'(mag[j]) * SQW'(mag[j]);
      prod_q[j] <= diff_q[j] * rgt_q[j];
    end
    roll_a_q <= in_word_i.rolloff_distance;
    roll_b_q <= roll_a_q;
    roll_c_q <= roll_b_q;
    sum_q    <= SUMW'(sq_q[0]) + SUMW'(sq_q[1]) + SUMW'(sq_q[2]);
    neg_q    <= dot[PW-1];
    dmag_q   <= dot[PW-1] ? PW'(-dot) : PW'(dot);
  end

  // distance
  logic                 vs;
  logic [RW-1:0]        src_len;
  logic [SBW-1:0]       sqrt_sb;
  logic [ROLL_BITS-1:0] roll_s;
  logic [PW-1:0]        dmag_s;
  logic                 neg_s;

  sarp_sqrt #(
    .SW (SUMW),
    .RW (RW),
    .SBW(SBW)
  ) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(vc_q),
    .rad_i  (sum_q),
    .sb_i   ({roll_c_q, dmag_q, neg_q}),
    .valid_o(vs),
    .root_o (src_len),
    .sb_o   (sqrt_sb)
  );

  assign {roll_s, dmag_s, neg_s} = sqrt_sb;

  // stage d: region decision and divider operands
  logic [ROLL_BITS:0] two_r;
  logic [RW-1:0]      fall;
  gain_flags_t        flags_d;

  assign two_r = {roll_s, 1'b0};
  assign fall  = RW'(two_r) - src_len;

  always_comb begin
    flags_d.zero_dist = (src_len == '0);
    flags_d.unity     = (RW'(roll_s) >= src_len);
    flags_d.silent    = (roll_s == '0) || (src_len >= RW'(two_r));
    // pan quotient would not fit the divider
    flags_d.pan_sat   = (CW'(dmag_s) >= (CW'(src_len) << QW));
  end

  logic                 vd_q;
  logic [GXW-1:0]       gx_q;
  logic [ROLL_BITS-1:0] roll_d_q;
  logic [PW-1:0]        dmag_d_q;
  logic [RW-1:0]        dist_d_q;
  logic                 neg_d_q;
  gain_flags_t          flags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
    end else begin
      vd_q <= vs;
    end
  end

  always_ff @(posedge clk_i) begin
    gx_q     <= {fall[ROLL_BITS-1:0], {FRAC_BITS{1'b0}}};
    roll_d_q <= roll_s;
    dmag_d_q <= dmag_s;
    dist_d_q <= src_len;
    neg_d_q  <= neg_s;
    flags_q  <= flags_d;
  end

  // gain and pan dividers, equal latency
  logic        vg, vp;
  logic [QW-1:0] qg, qp;
  gain_flags_t flags_e;
  logic        neg_e;

  sarp_div #(
    .XW (GXW),
    .DVW(ROLL_BITS),
    .QW (QW),
    .SBW($bits(gain_flags_t))
  ) u_gain_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(vd_q),
    .num_i  (gx_q),
    .den_i  (roll_d_q),
    .sb_i   (flags_q),
    .valid_o(vg),
    .quot_o (qg),
    .sb_o   (flags_e)
  );

  sarp_div #(
    .XW (PW),
    .DVW(RW),
    .QW (QW),
    .SBW(1)
  ) u_pan_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(vd_q),
    .num_i  (dmag_d_q),
    .den_i  (dist_d_q),
    .sb_i   (neg_d_q),
    .valid_o(vp),
    .quot_o (qp),
    .sb_o   (neg_e)
  );

  // stage e: final select into the output register
  logic [QW-1:0] pmag;
  out_t          out_d;
  out_t          out_q;
  logic          done_q;

  always_comb begin
    pmag = (flags_e.pan_sat || (qp > ONE_Q)) ? ONE_Q : qp;
    if (flags_e.zero_dist) begin
      out_d.gain = ONE_Q;
      out_d.pan  = '0;
    end else begin
      priority if (flags_e.unity) begin
        out_d.gain = ONE_Q;
      end else if (flags_e.silent) begin
        out_d.gain = '0;
      end else begin
        out_d.gain = qg;
      end
      out_d.pan = neg_e ? -VEC_BITS'(pmag) : VEC_BITS'(pmag);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vg & vp;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign done_o     = done_q;
  assign out_word_o = out_q;

  // checks
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LAT done_o)
    else $error("word lost in pipeline");

  a_div_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vg == vp)
    else $error("gain and pan dividers out of step");

  a_gain_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (out_word_o.gain <= ONE_Q))
    else $error("gain above unity");

  a_pan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((out_word_o.pan <= $signed(VEC_BITS'(ONE_Q)))
             && (out_word_o.pan >= -$signed(VEC_BITS'(ONE_Q)))))
    else $error("pan out of range");

endmodule

// ===== tb/spatial_audio_rolloff_pan_top_tb.sv =====
// ----------------------------------------------------------------------------
// spatial_audio_rolloff_pan_top_tb
// self-checking bench for the distance gain and stereo pan block: a directed
// table of corner words, then random words under several listener settings,
// each result compared against a hand-given value or a predictor of gain and pan
// ----------------------------------------------------------------------------
module spatial_audio_rolloff_pan_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sarp_pkg::*;

  localparam int DRAIN_CYCLES = 60;    // longer than the pipeline latency
  localparam int STALL_LIMIT  = 3000;  // cycles with no word moving
  localparam int RAND_PER_PHASE = 150;
  localparam int NUM_PHASES   = 7;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    start_i;
  logic                    busy_o;
  in_t                     in_word_i;
  logic                    done_o;
  out_t                    out_word_o;
  logic                    cfg_we_i;
  logic [REG_IDX_BITS-1:0] cfg_idx_i;
  logic [COORD_BITS-1:0]   cfg_wdata_i;

  spatial_audio_rolloff_pan_top dut (.*);

  always #5 clk_i = ~clk_i;

  // shadow copy of the listener registers
  logic signed [COORD_BITS-1:0] lst_pos [3];
  logic signed [VEC_BITS-1:0]   right_vec [3];

  out_t pending_results [$];
  int   mismatches = 0;
  int   words_in = 0;
  int   words_out = 0;
  bit   idling_on = 1'b1;

  typedef struct {
    in_t  w;
    bit   typed;   // expected result given by hand
    out_t res;
  } vec_row_t;

  // floor square root of the summed squares, bit by bit
  function automatic longint unsigned floor_sqrt(longint unsigned s);
    longint unsigned r = 0;
    longint unsigned c;
    for (int b = 26; b >= 0; b--) begin
      c = r | (longint'(1) << b);
      if (c * c <= s) r = c;
    end
    return r;
  endfunction

  function automatic out_t gain_pan_of(in_t w);
    longint          dif [3];
    longint unsigned sum = 0;
    longint          dot = 0;
    longint unsigned d, r, g, mag, pmag;
    out_t            o;
    dif[0] = longint'(w.source_x) - longint'(lst_pos[0]);
    dif[1] = longint'(w.source_y) - longint'(lst_pos[1]);
    dif[2] = longint'(w.source_z) - longint'(lst_pos[2]);
    for (int i = 0; i < 3; i++) begin
      sum += longint'(dif[i] * dif[i]);
      dot += longint'(right_vec[i]) * dif[i];
    end
    r = 64'(w.rolloff_distance);
    d = floor_sqrt(sum);
    if (d == 0) begin
      o.gain = ONE_Q;
      o.pan  = '0;
      return o;
    end
    if (d <= r) g = 64'(ONE_Q);
    else if (r == 0 || d >= 2 * r) g = 0;
    else g = ((2 * r - d) << FRAC_BITS) / r;
    mag  = (dot < 0) ? longint'(-dot) : longint'(dot);
    pmag = mag / d;
    if (pmag > ONE_Q) pmag = 64'(ONE_Q);
    o.gain = g[GAIN_BITS-1:0];
    o.pan  = (dot < 0) ? VEC_BITS'(-pmag) : VEC_BITS'(pmag);
    return o;
  endfunction

  // call right after a rising edge
  task automatic hold_off(int n);
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic send_word(in_t w, bit typed, out_t res);
    if (idling_on && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 12));
    start_i   <= 1'b1;
    in_word_i <= w;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    // word taken at this edge
    pending_results.insert(pending_results.size(), typed ? res : gain_pan_of(w));
    words_in++;
  endtask

  // the write enable is dropped by the caller once the last write is done
  task automatic write_reg(logic [REG_IDX_BITS-1:0] idx, logic [COORD_BITS-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    // unknown indexes leave the registers alone
    case (idx)
      REG_LISTENER_X, REG_LISTENER_Y, REG_LISTENER_Z: lst_pos[idx[1:0]] = val;
      REG_RIGHT_X, REG_RIGHT_Y, REG_RIGHT_Z:
        right_vec[2'(idx - REG_RIGHT_X)] = val[VEC_BITS-1:0];
      default: ;
    endcase
  endtask

  // let the pipeline empty before touching the registers
  task automatic wait_idle();
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic in_t random_word();
    in_t w;
    case ($urandom_range(0, 5))
      0: begin
        // anywhere in the coordinate range
        w.source_x = COORD_BITS'($urandom);
        w.source_y = COORD_BITS'($urandom);
        w.source_z = COORD_BITS'($urandom);
        w.rolloff_distance = ROLL_BITS'($urandom);
      end
      1, 2, 3: begin
        // near the listener, rolloff around the distance to reach the slope
        w.source_x = COORD_BITS'(lst_pos[0] + $signed(COORD_BITS'($urandom_range(0, 8191)) - 4096));
        w.source_y = COORD_BITS'(lst_pos[1] + $signed(COORD_BITS'($urandom_range(0, 8191)) - 4096));
        w.source_z = COORD_BITS'(lst_pos[2] + $signed(COORD_BITS'($urandom_range(0, 8191)) - 4096));
        w.rolloff_distance = ROLL_BITS'($urandom_range(0, 8192));
      end
      4: begin
        // on top of the listener or one step away
        w.source_x = COORD_BITS'(lst_pos[0] + $signed(COORD_BITS'($urandom_range(0, 2)) - 1));
        w.source_y = lst_pos[1];
        w.source_z = lst_pos[2];
        w.rolloff_distance = ROLL_BITS'($urandom);
      end
      default: begin
        // zero or full rolloff
        w.source_x = COORD_BITS'($urandom);
        w.source_y = COORD_BITS'($urandom);
        w.source_z = COORD_BITS'($urandom);
        w.rolloff_distance = $urandom_range(0, 1) ? '1 : '0;
      end
    endcase
    return w;
  endfunction

  function automatic in_t mk(int x, int y, int z, int r);
    in_t w;
    w.source_x = COORD_BITS'(x);
    w.source_y = COORD_BITS'(y);
    w.source_z = COORD_BITS'(z);
    w.rolloff_distance = ROLL_BITS'(r);
    return w;
  endfunction

  function automatic out_t mo(int g, int p);
    out_t o;
    o.gain = GAIN_BITS'(g);
    o.pan  = VEC_BITS'(p);
    return o;
  endfunction

  // result checker, the receiver never stalls
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      words_out++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word gain=%0d pan=%0d",
                                       out_word_o.gain, out_word_o.pan);
      end else begin
        out_t exp_w;
        exp_w = pending_results.pop_front();
        if (out_word_o.gain !== exp_w.gain || out_word_o.pan !== exp_w.pan) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result word %0d: gain exp %0d got %0d, pan exp %0d got %0d",
                     words_out, exp_w.gain, out_word_o.gain,
                     $signed(exp_w.pan), $signed(out_word_o.pan));
        end
      end
    end
  end

  // watchdog on cycles with nothing moving
  int stall_cnt = 0;
  always @(posedge clk_i) begin
    if (done_o || (start_i && !busy_o)) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    vec_row_t dir_rows [$];
    rst_ni      <= 1'b0;
    start_i     <= 1'b0;
    in_word_i   <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= '0;
    cfg_wdata_i <= '0;
    lst_pos[0] = '0; lst_pos[1] = '0; lst_pos[2] = '0;
    right_vec[0] = VEC_BITS'(ONE_Q); right_vec[1] = '0; right_vec[2] = '0;

    // default listener: origin, right vector (1, 0, 0)
    dir_rows.insert(dir_rows.size(), '{mk(0, 0, 0, 0), 1, mo(16384, 0)});     // zero distance
    dir_rows.insert(dir_rows.size(), '{mk(256, 0, 0, 512), 1, mo(16384, 16384)});
    dir_rows.insert(dir_rows.size(), '{mk(-256, 0, 0, 0), 1, mo(0, -16384)}); // zero rolloff
    dir_rows.insert(dir_rows.size(), '{mk(0, 256, 0, 100), 1, mo(0, 0)});     // past twice
    dir_rows.insert(dir_rows.size(), '{mk(300, 0, 0, 200), 1, mo(8192, 16384)});  // slope
    dir_rows.insert(dir_rows.size(), '{mk(256, 0, 0, 256), 1, mo(16384, 16384)}); // d == r
    dir_rows.insert(dir_rows.size(), '{mk(512, 0, 0, 256), 1, mo(0, 16384)});     // d == 2r
    dir_rows.insert(dir_rows.size(), '{mk(1, 0, 0, 8388607), 1, mo(16384, 16384)});
    dir_rows.insert(dir_rows.size(), '{mk(8388607, 8388607, 8388607, 8388607), 0, mo(0, 0)});
    dir_rows.insert(dir_rows.size(), '{mk(-8388608, -8388608, -8388608, 0), 0, mo(0, 0)});
    dir_rows.insert(dir_rows.size(), '{mk(8388607, -8388608, 8388607, 1), 0, mo(0, 0)});
    dir_rows.insert(dir_rows.size(), '{mk(-8388608, 8388607, -8388608, 4194304), 0, mo(0, 0)});
    dir_rows.insert(dir_rows.size(), '{mk(300, 400, 0, 300), 0, mo(0, 0)});   // pan rounding
    dir_rows.insert(dir_rows.size(), '{mk(-3, 1, 1, 2), 0, mo(0, 0)});  // full-scale pan, truncated d
    dir_rows.insert(dir_rows.size(), '{mk(0, 0, 7, 5), 0, mo(0, 0)});
    dir_rows.insert(dir_rows.size(), '{mk(1000, -1000, 1000, 1200), 0, mo(0, 0)});

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].res);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) begin
        wait_idle();
        case (ph)
          1: begin
            // lowest corner, right vector pointing the other way
            for (int i = 0; i < 3; i++)
              write_reg(REG_IDX_BITS'(REG_LISTENER_X + i), 24'h800000);
            write_reg(REG_RIGHT_X, 24'(-16384));
            write_reg(REG_RIGHT_Y, 24'(-16384));
            write_reg(REG_RIGHT_Z, 24'(-16384));
          end
          2: begin
            for (int i = 0; i < 3; i++)
              write_reg(REG_IDX_BITS'(REG_LISTENER_X + i), 24'h7fffff);
            write_reg(REG_RIGHT_X, 24'd16384);
            write_reg(REG_RIGHT_Y, 24'd16384);
            write_reg(REG_RIGHT_Z, 24'd16384);
          end
          3: begin
            // out-of-range right vector patterns, and writes to unused indexes
            write_reg(REG_LISTENER_X, '0);
            write_reg(REG_LISTENER_Y, '0);
            write_reg(REG_LISTENER_Z, '0);
            write_reg(REG_RIGHT_X, 24'hff8000);
            write_reg(REG_RIGHT_Y, 24'h007fff);
            write_reg(REG_RIGHT_Z, 24'h00c000);
            write_reg(REG_IDX_BITS'(NUM_REGS), COORD_BITS'($urandom));
            write_reg(REG_IDX_BITS'(NUM_REGS + 1), COORD_BITS'($urandom));
          end
          default: begin
            for (int i = 0; i < 8; i++) write_reg(REG_IDX_BITS'(i), COORD_BITS'($urandom));
            if (ph == NUM_PHASES - 1) idling_on = 1'b0;
          end
        endcase
        cfg_we_i <= 1'b0;
      end
      for (int n = 0; n < RAND_PER_PHASE; n++) send_word(random_word(), 0, mo(0, 0));
    end

    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d source words sent, %0d results checked, over %0d listener settings",
             words_in, words_out, NUM_PHASES);
    $display("covered zero distance, unity, slope, silence, pan saturation, %0d mismatches",
             mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
